### sv/nbms_pkg.sv
// Package for the neighbourhood best-match search unit.
// Shared constants, action codes and helper functions; no dependencies.
package nbms_pkg;
   localparam int MaxDim = 64;
   localparam int DimW = $clog2(MaxDim);
   localparam int StoreDepth = MaxDim * MaxDim;
   localparam int AddrW = $clog2(StoreDepth);
   localparam int WinTaps = 9;
   localparam int TapW = $clog2(WinTaps);

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   function automatic logic [6:0] clamp_dim(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) r = 7'd1;
      else if (v > 7'(MaxDim)) r = 7'(MaxDim);
      return r;
   endfunction

   function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [9:0] color_sad(input logic [23:0] p, input logic [23:0] q);
      return 10'(absdiff8(p[23:16], q[23:16])) + 10'(absdiff8(p[15:8], q[15:8]))
           + 10'(absdiff8(p[7:0], q[7:0]));
   endfunction
endpackage

### sv/nbms_store.sv
// Exemplar pixel store: synchronous RAM, one write and one read port.
// Depends on nbms_pkg.
module nbms_store import nbms_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [23:0]      wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [23:0]      rd_data
);
   logic [23:0] mem [StoreDepth];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### sv/neighbourhood_best_match_search_unit.sv
// Top level of the neighbourhood best-match search unit.
// Depends on nbms_pkg and nbms_store.
//
//  channel | dir | ports
//  req     | in  | req_action, req_load_addr, req_load_color, req_pixel_0..8
//  rsp     | out | rsp_best_color, rsp_best_position, rsp_min_score, rsp_energy_total
//  csr     | in  | csr_index, csr_data
//
// A query reads nine pixels per window through the single store read port;
// no request is taken until the query is done.
// Reset clears control state, energy total and sets both dimensions to 64.
// A query result waits in the output register; loads and clears are taken
// meanwhile, a query is held until the result is taken.
module neighbourhood_best_match_search_unit import nbms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_load_addr,
   input  logic [23:0] req_load_color,
   input  logic [23:0] req_pixel_0,
   input  logic [23:0] req_pixel_1,
   input  logic [23:0] req_pixel_2,
   input  logic [23:0] req_pixel_3,
   input  logic [23:0] req_pixel_4,
   input  logic [23:0] req_pixel_5,
   input  logic [23:0] req_pixel_6,
   input  logic [23:0] req_pixel_7,
   input  logic [23:0] req_pixel_8,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_best_color,
   output logic [11:0] rsp_best_position,
   output logic [12:0] rsp_min_score,
   output logic [31:0] rsp_energy_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [6:0]  width_ff, height_ff;
   logic [6:0]  w_ff, h_ff;
   logic [23:0] query_ff [WinTaps];
   logic [DimW-1:0] x_ff, x_in, y_ff, y_in;
   logic [TapW-1:0] tap_ff, tap_in;
   logic        last_ff, last_in, rd_live_ff;
   logic [TapW-1:0] rd_tap_ff;
   logic        rd_last_ff;
   logic [AddrW-1:0] rd_pos_ff;
   logic [12:0] score_ff, score_in;
   logic [12:0] best_ff;
   logic        found_ff;
   logic [AddrW-1:0] best_pos_ff, pos_ff;
   logic [23:0] center_ff;
   logic [31:0] energy_ff, energy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_color_ff;
   logic [11:0] rsp_pos_ff;
   logic [12:0] rsp_score_ff;
   logic [31:0] rsp_energy_ff;

   logic        req_fire, done_all, better;
   logic [AddrW-1:0] rd_addr;
   logic [23:0] rd_data;
   logic [DimW:0] xx, yy;
   logic [12:0] sum;
   logic [32:0] esum;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && !(req_action == ACT_QUERY && rsp_valid_ff);
   assign req_fire = req_valid && req_ready;

   // tap k: dx = k/3 - 1, dy = k%3 - 1
   always_comb begin
      logic [1:0] dxi, dyi;
      logic [7:0] t;
      logic [13:0] a;
      dxi = (tap_ff < 4'd3) ? 2'd0 : (tap_ff < 4'd6) ? 2'd1 : 2'd2;
      dyi = 2'(tap_ff - 4'(dxi) * 4'd3);
      t = 8'(x_ff) + 8'(w_ff) + 8'(dxi) - 8'd1;
      if (t >= 8'(w_ff)) t = t - 8'(w_ff);
      if (t >= 8'(w_ff)) t = t - 8'(w_ff);
      xx = (DimW+1)'(t);
      t = 8'(y_ff) + 8'(h_ff) + 8'(dyi) - 8'd1;
      if (t >= 8'(h_ff)) t = t - 8'(h_ff);
      if (t >= 8'(h_ff)) t = t - 8'(h_ff);
      yy = (DimW+1)'(t);
      a = 14'(yy) * 14'(w_ff) + 14'(xx);
      rd_addr = AddrW'(a);
   end

   nbms_store u_store (
      .clock   (clock),
      .wr_en   (req_fire && req_action == ACT_LOAD),
      .wr_addr (req_load_addr),
      .wr_data (req_load_color),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      tap_in = tap_ff;
      last_in = last_ff;
      done_all = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_action == ACT_QUERY) begin
               state_in = ST_SCAN;
               x_in = '0;
               y_in = '0;
               tap_in = '0;
               last_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (!last_ff) begin
               if (tap_ff == TapW'(WinTaps - 1)) begin
                  tap_in = '0;
                  if (7'(x_ff) == w_ff - 7'd1) begin
                     x_in = '0;
                     if (7'(y_ff) == h_ff - 7'd1) done_all = 1'b1;
                     else y_in = y_ff + DimW'(1);
                  end else x_in = x_ff + DimW'(1);
               end else tap_in = tap_ff + TapW'(1);
               if (done_all) last_in = 1'b1;
            end else if (!rd_live_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      score_in = (rd_tap_ff == '0 ? 13'd0 : score_ff) +
                 13'(color_sad(query_ff[rd_tap_ff], rd_data));
      sum = score_in;
      better = rd_live_ff && rd_last_ff && (!found_ff || sum < best_ff);
      esum = 33'(energy_ff) + 33'(best_ff);
      energy_in = energy_ff;
      if (state_ff == ST_DONE) energy_in = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
      else if (req_fire && req_action == ACT_CLEAR) energy_in = '0;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_DONE) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= 7'd64;
         height_ff <= 7'd64;
         x_ff <= '0;
         y_ff <= '0;
         tap_ff <= '0;
         last_ff <= 1'b0;
         energy_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH) width_ff <= csr_data;
            else height_ff <= csr_data;
         end
         state_ff <= state_in;
         x_ff <= x_in;
         y_ff <= y_in;
         tap_ff <= tap_in;
         last_ff <= last_in;
         energy_ff <= energy_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff <= (state_ff == ST_SCAN) && !last_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_tap_ff <= tap_ff;
      rd_last_ff <= (state_ff == ST_SCAN) && tap_ff == TapW'(WinTaps - 1);
      rd_pos_ff <= AddrW'(14'(y_ff) * 14'(w_ff) + 14'(x_ff));
      if (req_fire && req_action == ACT_QUERY) begin
         w_ff <= clamp_dim(width_ff);
         h_ff <= clamp_dim(height_ff);
         found_ff <= 1'b0;
         query_ff[0] <= req_pixel_0; query_ff[1] <= req_pixel_1;
         query_ff[2] <= req_pixel_2; query_ff[3] <= req_pixel_3;
         query_ff[4] <= req_pixel_4; query_ff[5] <= req_pixel_5;
         query_ff[6] <= req_pixel_6; query_ff[7] <= req_pixel_7;
         query_ff[8] <= req_pixel_8;
      end else if (better) begin
         found_ff <= 1'b1;
      end
      if (rd_live_ff) begin
         score_ff <= sum;
         if (rd_tap_ff == TapW'(4)) center_ff <= rd_data;
         if (rd_tap_ff == TapW'(0)) pos_ff <= rd_pos_ff;
      end
      if (better) begin
         best_ff <= sum;
         rsp_color_ff <= center_ff;
         best_pos_ff <= pos_ff;
      end
      if (state_ff == ST_DONE) begin
         rsp_score_ff <= best_ff;
         rsp_pos_ff <= best_pos_ff;
         rsp_energy_ff <= energy_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_best_color = rsp_color_ff;
   assign rsp_best_position = rsp_pos_ff;
   assign rsp_min_score = rsp_score_ff;
   assign rsp_energy_total = rsp_energy_ff;
endmodule
